// ===== rtl/texture_tile_rgba4444_encoder_assert.svh =====
// Assertion macros for the RGBA4444 tile encoder.
`ifndef TEXTURE_TILE_RGBA4444_ENCODER_ASSERT_SVH
`define TEXTURE_TILE_RGBA4444_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TTENC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tile encoder check failed");

// Next-cycle implication, disabled while in reset.
`define TTENC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tile encoder check failed");

`endif

// ===== rtl/ttenc_pkg.sv =====
// Types, constants and helpers shared by the RGBA4444 tile encoder.
package ttenc_pkg;

  localparam int unsigned TileEdge  = 8;
  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned NibW      = 4;
  localparam int unsigned PixW      = 16;
  localparam int unsigned PosW      = 6;
  localparam int unsigned WidthW    = 12;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned SubW      = $clog2(TileEdge);
  localparam int unsigned BlkW      = ColW - SubW;
  localparam int unsigned AddrW     = SubW + ColW;
  localparam int unsigned Depth     = TileEdge * MaxWidth;

  localparam logic [WidthW-1:0] WidthReset = WidthW'(256);
  localparam logic [WidthW-1:0] WidthMin   = WidthW'(TileEdge);
  localparam logic [WidthW-1:0] WidthMax   = WidthW'(MaxWidth);
  localparam logic [PosW-1:0]   LastPos    = PosW'(TileEdge * TileEdge - 1);
  localparam logic [SubW-1:0]   LastSub    = SubW'(TileEdge - 1);

  // floor(v / 17) for v < 256: (v * 241) >> 12 is exact over that range
  localparam logic [15:0] ChanRecip = 16'd241;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  function automatic logic [NibW-1:0] reduce_channel(input logic [ChanW-1:0] v);
    logic [15:0] prod;
    prod = 16'(v) * ChanRecip;
    return prod[15:12];
  endfunction

  function automatic logic [PixW-1:0] pack_pixel(input logic [ChanW-1:0] r,
                                                 input logic [ChanW-1:0] g,
                                                 input logic [ChanW-1:0] b,
                                                 input logic [ChanW-1:0] a);
    return {reduce_channel(r), reduce_channel(g), reduce_channel(b), reduce_channel(a)};
  endfunction

endpackage

// ===== rtl/ttenc_pix_if.sv =====
// Pixel input channel: valid/ready handshake with RGBA8888 payload.
interface ttenc_pix_if;
  logic                           valid;
  logic                           ready;
  logic [ttenc_pkg::ChanW-1:0]    red;
  logic [ttenc_pkg::ChanW-1:0]    green;
  logic [ttenc_pkg::ChanW-1:0]    blue;
  logic [ttenc_pkg::ChanW-1:0]    alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);
endinterface

// ===== rtl/ttenc_res_if.sv =====
// Result channel: valid/ready handshake with tiled RGBA4444 payload.
interface ttenc_res_if;
  logic                         valid;
  logic                         ready;
  logic [ttenc_pkg::PixW-1:0]   packed_pixel;
  logic [ttenc_pkg::PosW-1:0]   tile_position;
  logic                         block_last;

  modport source (output valid, output packed_pixel, output tile_position,
                  output block_last, input ready);
  modport sink (input valid, input packed_pixel, input tile_position,
                input block_last, output ready);
endinterface

// ===== rtl/texture_tile_rgba4444_encoder.sv =====
// Throughput: one pixel per cycle while filling; a pixel that completes an 8x8 block stalls
// the input while the block drains from the single band store read port.
// The completing transaction moves the state to drain; the first tile read then loads the output register.
// Results go out one per cycle unless the sink stalls; the output register holds meanwhile.
// Reset: asynchronous active low; counters cleared, width 256; band store is not cleared.
module texture_tile_rgba4444_encoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ttenc_pix_if.sink                       pix_i,
  ttenc_res_if.source                     res_o,
  input  logic                            cfg_we_i,
  input  logic [ttenc_pkg::WidthW-1:0]    cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  ttenc_pkg::state_e                state_q, state_d;
  logic [ttenc_pkg::WidthW-1:0]     width_q;
  logic [ttenc_pkg::ColW-1:0]       col_q, col_d;
  logic [ttenc_pkg::SubW-1:0]       row_q, row_d;
  logic [ttenc_pkg::BlkW-1:0]       blk_q, blk_d;   // block column being drained
  logic [ttenc_pkg::PosW-1:0]       cnt_q, cnt_d;   // next tile index to read
  logic                             out_valid_q, out_valid_d;

  // Output payload registers (no reset)
  logic [ttenc_pkg::PixW-1:0]       pix_q;
  logic [ttenc_pkg::PosW-1:0]       pos_q;
  logic                             last_q;

  // Band store: TileEdge rows x MaxWidth columns, address = {row, column}
  logic [ttenc_pkg::PixW-1:0]       band_store_q [ttenc_pkg::Depth];

  logic                             in_fire;
  logic                             emit;
  logic                             wrap;
  logic                             issue;
  logic [ttenc_pkg::WidthW-1:0]     w_mask;
  logic [ttenc_pkg::WidthW-1:0]     w_eff;
  logic [ttenc_pkg::WidthW-1:0]     col_inc;
  logic [ttenc_pkg::AddrW-1:0]      wr_addr;
  logic [ttenc_pkg::AddrW-1:0]      rd_addr;
  logic [ttenc_pkg::SubW-1:0]       tx, ty;
  logic [ttenc_pkg::PixW-1:0]       wr_data;

  // Input accepted only between block drains.
  assign pix_i.ready = (state_q == ttenc_pkg::ST_IDLE);
  assign in_fire     = pix_i.valid && pix_i.ready;

  // Effective width: rounded down to a multiple of 8, clamped to [8, 2048].
  assign w_mask = {width_q[ttenc_pkg::WidthW-1:ttenc_pkg::SubW], ttenc_pkg::SubW'(0)};
  always_comb begin
    if (w_mask < ttenc_pkg::WidthMin) begin
      w_eff = ttenc_pkg::WidthMin;
    end else if (w_mask > ttenc_pkg::WidthMax) begin
      w_eff = ttenc_pkg::WidthMax;
    end else begin
      w_eff = w_mask;
    end
  end

  // Row wraps when the next column reaches the width; a column already past a
  // narrowed width still stores in place and wraps right after.
  assign col_inc = ttenc_pkg::WidthW'(col_q) + ttenc_pkg::WidthW'(1);
  assign wrap    = (col_inc >= w_eff);

  // Last row of the band, last column of a block: the block is complete.
  assign emit = (row_q == ttenc_pkg::LastSub) &&
                (col_q[ttenc_pkg::SubW-1:0] == ttenc_pkg::LastSub);

  assign wr_addr = {row_q, col_q};
  assign wr_data = ttenc_pkg::pack_pixel(pix_i.red, pix_i.green, pix_i.blue, pix_i.alpha);

  // Morton split of the tile index: x from even bits, y from odd bits.
  assign tx      = {cnt_q[4], cnt_q[2], cnt_q[0]};
  assign ty      = {cnt_q[5], cnt_q[3], cnt_q[1]};
  assign rd_addr = {ty, blk_q, tx};

  // During a drain, issue a read whenever the output register is free or being emptied. The
  // RAM read register doubles as the output register, so a stall simply holds it.
  assign issue = (state_q == ttenc_pkg::ST_DRAIN) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    blk_d       = blk_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;

    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ttenc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (wrap) begin
            col_d = '0;
            row_d = row_q + ttenc_pkg::SubW'(1);
          end else begin
            col_d = col_inc[ttenc_pkg::ColW-1:0];
          end
          if (emit) begin
            state_d = ttenc_pkg::ST_DRAIN;
            blk_d   = col_q[ttenc_pkg::ColW-1:ttenc_pkg::SubW];
            cnt_d   = '0;
          end
        end
      end
      ttenc_pkg::ST_DRAIN: begin
        if (issue) begin
          out_valid_d = 1'b1;
          cnt_d       = cnt_q + ttenc_pkg::PosW'(1);
          if (cnt_q == ttenc_pkg::LastPos) begin
            state_d = ttenc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ttenc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttenc_pkg::ST_IDLE;
      width_q     <= ttenc_pkg::WidthReset;
      col_q       <= '0;
      row_q       <= '0;
      blk_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      blk_q       <= blk_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
    end
  end

  // Band store: one write port (input pixels), one registered read port (drain).
  // Writes and reads never overlap on the same entry: reads are issued only in the drain
  // state, which begins after the completing pixel is written.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      band_store_q[wr_addr] <= wr_data;
    end
    if (issue) begin
      pix_q <= band_store_q[rd_addr];
    end
  end

  // Tile index and last flag travel alongside the read data.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      pos_q  <= cnt_q;
      last_q <= (cnt_q == ttenc_pkg::LastPos);
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.packed_pixel  = pix_q;
  assign res_o.tile_position = pos_q;
  assign res_o.block_last    = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "texture_tile_rgba4444_encoder_assert.svh"

  // A completing pixel starts a drain from tile index zero.
  `TTENC_ASSERT_NEXT(a_drain_start, clk_i, rst_ni, in_fire && emit, (state_q == ttenc_pkg::ST_DRAIN) && (cnt_q == '0))
  // While the last tile pixel is held, the next block has issued no read yet.
  `TTENC_ASSERT_NOW(a_last_hold, clk_i, rst_ni, res_o.valid && res_o.block_last, cnt_q == '0)
  // Within a block, results follow back to back in tile order.
  `TTENC_ASSERT_NEXT(a_pos_seq, clk_i, rst_ni, res_o.valid && res_o.ready && !res_o.block_last, res_o.valid && (res_o.tile_position == ttenc_pkg::PosW'($past(res_o.tile_position) + ttenc_pkg::PosW'(1))))

endmodule
